[hw/rtl/tssa_pkg.sv]
package tssa_pkg;

	localparam int CNT_W = 5;
	localparam int OUT_W = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_PEEK       = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic accept;
		logic rd;
		logic load;
	} tssa_cmd_t;

endpackage

[hw/rtl/two_stacks_shared_array_core.sv]
// Channel   Handshake                  Payload
// in        in_valid / in_stall        opcode, push_value
// out       out_valid / out_stall      front_top, front_valid, back_top, back_valid,
//                                      both_empty, array_full, status
// cfg       cfg_wr_en                  cfg_wr_data (capacity in use)
//
// Each request passes through accept and store update, word store read, and result load, in that order.
// The word store read and the result are both registered; a new request is taken only once
// the previous one has loaded its result.
// Reset empties both stacks and sets the capacity to the smaller of 16 and DEPTH.
// A stalled result holds its register, and the request in flight waits at the load step until it is free.
module two_stacks_shared_array_core #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tssa_pkg::CNT_W-1:0]        cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        opcode,
	input  logic signed [tssa_pkg::OUT_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tssa_pkg::OUT_W-1:0] front_top,
	output logic                              front_valid,
	output logic signed [tssa_pkg::OUT_W-1:0] back_top,
	output logic                              back_valid,
	output logic                              both_empty,
	output logic                              array_full,
	output logic [1:0]                        status
);

	import tssa_pkg::*;

	tssa_cmd_t cmd;

	tssa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tssa_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.opcode      (opcode),
		.push_value  (push_value),
		.front_top   (front_top),
		.front_valid (front_valid),
		.back_top    (back_top),
		.back_valid  (back_valid),
		.both_empty  (both_empty),
		.array_full  (array_full),
		.status      (status)
	);

endmodule

[hw/rtl/tssa_ram.sv]
module tssa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[hw/rtl/tssa_ctrl.sv]
module tssa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output tssa_pkg::tssa_cmd_t cmd
);

	import tssa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.rd     = (state_q == S_READ);
		cmd.load   = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/tssa_dp.sv]
module tssa_dp #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tssa_pkg::tssa_cmd_t         cmd,
	input  logic                        cfg_wr_en,
	input  logic [tssa_pkg::CNT_W-1:0]  cfg_wr_data,
	input  logic [2:0]                  opcode,
	input  logic signed [tssa_pkg::OUT_W-1:0] push_value,
	output logic signed [tssa_pkg::OUT_W-1:0] front_top,
	output logic                        front_valid,
	output logic signed [tssa_pkg::OUT_W-1:0] back_top,
	output logic                        back_valid,
	output logic                        both_empty,
	output logic                        array_full,
	output logic [1:0]                  status
);

	import tssa_pkg::*;

	localparam int AW      = $clog2(DEPTH);
	localparam int CAP_RST = (16 < DEPTH) ? 16 : DEPTH;

	cnt_t       cap_q;
	cnt_t       front_cnt_q;
	cnt_t       back_cnt_q;
	logic [1:0] status_q;

	logic [CNT_W:0]       used;
	logic                 full;
	logic                 we;
	cnt_t                 widx;
	logic [WORD_BITS-1:0] wdata;
	cnt_t                 fidx;
	cnt_t                 bidx;
	logic [WORD_BITS-1:0] rdata_a;
	logic [WORD_BITS-1:0] rdata_b;
	logic signed [63:0]   front_ext;
	logic signed [63:0]   back_ext;

	logic signed [OUT_W-1:0] front_top_q;
	logic signed [OUT_W-1:0] back_top_q;
	logic                    front_valid_q;
	logic                    back_valid_q;
	logic                    both_empty_q;
	logic                    array_full_q;
	logic [1:0]              status_out_q;

	assign used  = {1'b0, front_cnt_q} + {1'b0, back_cnt_q};
	assign full  = used >= {1'b0, cap_q};
	assign wdata = WORD_BITS'($unsigned(push_value));

	always_comb begin
		we   = 1'b0;
		widx = front_cnt_q;
		if (cmd.accept && !full) begin
			if (opcode == OP_PUSH_FRONT) begin
				we = 1'b1;
			end else if (opcode == OP_PUSH_BACK) begin
				we   = 1'b1;
				widx = cap_q - back_cnt_q - cnt_t'(1);
			end
		end
	end

	assign fidx = front_cnt_q - cnt_t'(1);
	assign bidx = cap_q - back_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= cnt_t'(CAP_RST);
			front_cnt_q <= '0;
			back_cnt_q  <= '0;
			status_q    <= ST_DONE;
		end else if (cfg_wr_en) begin
			if (int'(cfg_wr_data) > DEPTH) begin
				cap_q <= cnt_t'(DEPTH);
			end else begin
				cap_q <= cfg_wr_data;
			end
			front_cnt_q <= '0;
			back_cnt_q  <= '0;
		end else if (cmd.accept) begin
			status_q <= ST_DONE;
			case (opcode)
				OP_PUSH_FRONT: begin
					if (full) begin
						status_q <= ST_REFUSED;
					end else begin
						front_cnt_q <= front_cnt_q + cnt_t'(1);
					end
				end
				OP_PUSH_BACK: begin
					if (full) begin
						status_q <= ST_REFUSED;
					end else begin
						back_cnt_q <= back_cnt_q + cnt_t'(1);
					end
				end
				OP_POP_FRONT: begin
					if (front_cnt_q == '0) begin
						status_q <= ST_IGNORED;
					end else begin
						front_cnt_q <= front_cnt_q - cnt_t'(1);
					end
				end
				OP_POP_BACK: begin
					if (back_cnt_q == '0) begin
						status_q <= ST_IGNORED;
					end else begin
						back_cnt_q <= back_cnt_q - cnt_t'(1);
					end
				end
				default: begin
					status_q <= ST_DONE;
				end
			endcase
		end
	end

	tssa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (AW'(widx)),
		.wdata   (wdata),
		.re      (cmd.rd),
		.raddr_a (AW'(fidx)),
		.raddr_b (AW'(bidx)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign front_ext = 64'(signed'(rdata_a));
	assign back_ext  = 64'(signed'(rdata_b));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			front_valid_q <= (front_cnt_q != '0);
			back_valid_q  <= (back_cnt_q != '0);
			front_top_q   <= (front_cnt_q != '0) ? front_ext[OUT_W-1:0] : '1;
			back_top_q    <= (back_cnt_q != '0) ? back_ext[OUT_W-1:0] : '1;
			both_empty_q  <= (front_cnt_q == '0) && (back_cnt_q == '0);
			array_full_q  <= full;
			status_out_q  <= status_q;
		end
	end

	assign front_top   = front_top_q;
	assign front_valid = front_valid_q;
	assign back_top    = back_top_q;
	assign back_valid  = back_valid_q;
	assign both_empty  = both_empty_q;
	assign array_full  = array_full_q;
	assign status      = status_out_q;

endmodule
